### design/vnw_pkg.sv
`timescale 1ns / 1ps

package vnw_pkg;

  // Field widths of one input word and one result word.
  localparam int SAMPLE_W      = 8;
  localparam int BYTE_W        = 8;
  localparam int POOL_IDX_W    = 6;
  localparam int BLOCK_W       = 16;
  localparam int BIT_CNT_W     = 3;

  // Three bit pairs are taken from the low bits of each sample.
  localparam int PAIR_COUNT    = 3;

  // Register reset value and default ring size.
  localparam logic [BLOCK_W-1:0] BLOCK_BYTES_RESET = 16'd10000;
  localparam int POOL_BYTES_DEFAULT = 64;

  // Stream packing: tdata = {pool_index, pool_byte, white_byte}, padded to bytes.
  localparam int TDATA_USED_W  = BYTE_W + BYTE_W + POOL_IDX_W;
  localparam int TDATA_W       = ((TDATA_USED_W + 7) / 8) * 8;
  // tuser = {pool_filled, pool_valid, white_valid}.
  localparam int TUSER_W       = 3;

  // One result word as produced by the packing core.
  typedef struct packed {
    logic                  white_valid;
    logic [BYTE_W-1:0]     white_byte;
    logic                  block_end;
    logic                  pool_valid;
    logic [BYTE_W-1:0]     pool_byte;
    logic [POOL_IDX_W-1:0] pool_index;
    logic                  pool_filled;
  } vnw_result_t;

endpackage

### design/von_neumann_whitener_with_discard_pool.sv
`timescale 1ns / 1ps
// Path: a word accepted on the input waits in the input register, passes the combinational
// packing core and is registered in the result register that drives out_.
// Throughput: one word per cycle while the output is taken; packing is combinational.
// While a result waits at the output the input register still takes one word, then stalls.
// Reset (rst_n low, synchronous) clears all packing state and the ring position,
// empties both registers and loads block_bytes with 10000.

module von_neumann_whitener_with_discard_pool #(
  parameter int POOL_BYTES = vnw_pkg::POOL_BYTES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input stream.
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [vnw_pkg::SAMPLE_W-1:0]  in_tdata,   // [7:0] sample
  // Result stream.
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [vnw_pkg::TDATA_W-1:0]   out_tdata,  // [7:0] white_byte, [15:8] pool_byte,
                                                    // [21:16] pool_index, [23:22] zero
  output logic [vnw_pkg::TUSER_W-1:0]   out_tuser,  // [0] white_valid, [1] pool_valid,
                                                    // [2] pool_filled
  output logic                          out_tlast,  // block_end
  // Configuration.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vnw_pkg::BLOCK_W-1:0]   cfg_data    // block_bytes
);
  import vnw_pkg::*;

  logic                 in_valid_r;
  logic [SAMPLE_W-1:0]  sample_r;
  logic                 out_valid_r;
  vnw_result_t          res_r;
  vnw_result_t          res;
  logic [BLOCK_W-1:0]   block_bytes_r;
  logic                 load;

  // A word moves to the output when the output register is free or draining.
  assign load      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || load;
  assign cfg_ready = 1'b1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_bytes_r <= BLOCK_BYTES_RESET;
    end else if (cfg_valid) begin
      block_bytes_r <= cfg_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      sample_r <= in_tdata;
    end
  end

  vnw_core #(
    .POOL_BYTES (POOL_BYTES)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (load),
    .sample      (sample_r),
    .block_bytes (block_bytes_r),
    .result      (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(TDATA_W-TDATA_USED_W){1'b0}},
                       res_r.pool_index, res_r.pool_byte, res_r.white_byte};
  assign out_tuser  = {res_r.pool_filled, res_r.pool_valid, res_r.white_valid};
  assign out_tlast  = res_r.block_end;

endmodule

### design/vnw_core.sv
`timescale 1ns / 1ps

module vnw_core #(
  parameter int POOL_BYTES = vnw_pkg::POOL_BYTES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic [vnw_pkg::SAMPLE_W-1:0]  sample,
  input  logic [vnw_pkg::BLOCK_W-1:0]   block_bytes,
  output vnw_pkg::vnw_result_t          result
);
  import vnw_pkg::*;

  localparam int POS_W = (POOL_BYTES > 1) ? $clog2(POOL_BYTES) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(POOL_BYTES - 1);

  // Packing state.
  logic [BYTE_W-1:0]    white_partial_r, white_partial_nxt;
  logic [BIT_CNT_W-1:0] white_cnt_r, white_cnt_nxt;
  logic [BLOCK_W-1:0]   block_cnt_r, block_cnt_nxt;
  logic [BYTE_W-1:0]    pool_partial_r, pool_partial_nxt;
  logic [BIT_CNT_W-1:0] pool_cnt_r, pool_cnt_nxt;
  logic [POS_W-1:0]     pool_pos_r, pool_pos_nxt;
  logic                 pool_wrapped_r, pool_wrapped_nxt;

  // Walk the three pairs in order; each one feeds one of the two packers.
  always_comb begin
    logic a;
    logic b;
    white_partial_nxt   = white_partial_r;
    white_cnt_nxt       = white_cnt_r;
    block_cnt_nxt       = block_cnt_r;
    pool_partial_nxt    = pool_partial_r;
    pool_cnt_nxt        = pool_cnt_r;
    pool_pos_nxt        = pool_pos_r;
    pool_wrapped_nxt    = pool_wrapped_r;
    result.white_valid  = 1'b0;
    result.white_byte   = '0;
    result.block_end    = 1'b0;
    result.pool_valid   = 1'b0;
    result.pool_byte    = '0;
    result.pool_index   = '0;
    for (int k = 0; k < PAIR_COUNT; k++) begin
      a = sample[2*k];
      b = sample[2*k+1];
      if (a != b) begin
        white_partial_nxt[white_cnt_nxt] = a;
        if (white_cnt_nxt == '1) begin
          // Byte complete: emit and advance the block counter.
          result.white_valid = 1'b1;
          result.white_byte  = white_partial_nxt;
          white_partial_nxt  = '0;
          white_cnt_nxt      = '0;
          if (({1'b0, block_cnt_nxt} + 17'd1) >= {1'b0, block_bytes}) begin
            result.block_end = 1'b1;
            block_cnt_nxt    = '0;
          end else begin
            block_cnt_nxt = block_cnt_nxt + 1'b1;
          end
        end else begin
          white_cnt_nxt = white_cnt_nxt + 1'b1;
        end
      end else begin
        pool_partial_nxt[pool_cnt_nxt] = a;
        if (pool_cnt_nxt == '1) begin
          // Pool byte complete: report the low bits of its ring slot and step the ring.
          result.pool_valid = 1'b1;
          result.pool_byte  = pool_partial_nxt;
          result.pool_index = POOL_IDX_W'(pool_pos_nxt);
          pool_partial_nxt  = '0;
          pool_cnt_nxt      = '0;
          if (pool_pos_nxt == POS_LAST) begin
            pool_pos_nxt     = '0;
            pool_wrapped_nxt = 1'b1;
          end else begin
            pool_pos_nxt = pool_pos_nxt + 1'b1;
          end
        end else begin
          pool_cnt_nxt = pool_cnt_nxt + 1'b1;
        end
      end
    end
    result.pool_filled = pool_wrapped_nxt;
  end

  // State advances only when a word is processed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      white_partial_r <= '0;
      white_cnt_r     <= '0;
      block_cnt_r     <= '0;
      pool_partial_r  <= '0;
      pool_cnt_r      <= '0;
      pool_pos_r      <= '0;
      pool_wrapped_r  <= 1'b0;
    end else if (en) begin
      white_partial_r <= white_partial_nxt;
      white_cnt_r     <= white_cnt_nxt;
      block_cnt_r     <= block_cnt_nxt;
      pool_partial_r  <= pool_partial_nxt;
      pool_cnt_r      <= pool_cnt_nxt;
      pool_pos_r      <= pool_pos_nxt;
      pool_wrapped_r  <= pool_wrapped_nxt;
    end
  end

endmodule

### verif/von_neumann_whitener_with_discard_pool_test.sv
`timescale 1ns / 1ps

module von_neumann_whitener_with_discard_pool_test;
  import vnw_pkg::*;

  localparam int RING_BYTES   = POOL_BYTES_DEFAULT;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_WAIT  = 8;
  localparam int MAX_PRINTS   = 40;
  localparam int DEFAULT_IDLE = 10;
  localparam int RESET_CYCLES = 11;

  // Shapes of generated samples: free bits, pairs forced to differ or to match, or one
  // solid value across the byte. Mixed picks among them per word.
  typedef enum int {KIND_ANY, KIND_UNEQUAL, KIND_EQUAL, KIND_SOLID, KIND_MIXED} sample_kind_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [SAMPLE_W-1:0] in_tdata   = '0;   // [7:0] sample
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [TDATA_W-1:0]  out_tdata;         // [7:0] white_byte, [15:8] pool_byte,
                                          // [21:16] pool_index, [23:22] zero
  logic [TUSER_W-1:0]  out_tuser;         // [0] white_valid, [1] pool_valid, [2] pool_filled
  logic                out_tlast;         // block_end
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [BLOCK_W-1:0]  cfg_data   = '0;   // block_bytes

  // Predictor state, mirroring the block after reset.
  logic [BLOCK_W-1:0]   block_len    = BLOCK_BYTES_RESET;
  logic [BYTE_W-1:0]    white_acc    = '0;
  logic [BIT_CNT_W-1:0] white_fill   = '0;
  int                   block_fill   = 0;
  logic [BYTE_W-1:0]    pool_acc     = '0;
  logic [BIT_CNT_W-1:0] pool_fill    = '0;
  int                   ring_pos     = 0;
  logic                 ring_wrapped = 1'b0;

  vnw_result_t whitened_words_due [$];

  int src_idle_pct    = DEFAULT_IDLE;
  int sink_idle_pct   = DEFAULT_IDLE;
  int sink_hold_left  = 0;
  int samples_sent    = 0;
  int results_checked = 0;
  int block_ends      = 0;
  int cfg_writes      = 0;
  int mismatches      = 0;
  int cycle_count     = 0;
  bit ring_seen_full  = 1'b0;

  logic [SAMPLE_W-1:0] pair_patterns [0:21] = '{
    8'h00, 8'hFF, 8'h3F, 8'hC0, 8'h15, 8'h2A, 8'h15, 8'h2A, 8'h0C, 8'h33, 8'h99,
    8'h66, 8'h80, 8'h40, 8'h1B, 8'h24, 8'h39, 8'hC6, 8'hA5, 8'h5A, 8'h7E, 8'h81
  };

  von_neumann_whitener_with_discard_pool uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin : clock_gen
    forever #10 clk = ~clk;
  end

  // Run the three bit pairs of one sample through both packers and return the word
  // that the block should produce for it.
  function automatic vnw_result_t whiten_sample(input logic [SAMPLE_W-1:0] smp);
    vnw_result_t r;
    logic        first_bit;
    r = '0;
    for (int k = 0; k < PAIR_COUNT; k++) begin
      first_bit = smp[2*k];
      if (first_bit != smp[2*k+1]) begin
        white_acc[white_fill] = first_bit;
        if (white_fill == '1) begin
          r.white_valid = 1'b1;
          r.white_byte  = white_acc;
          white_acc     = '0;
          white_fill    = '0;
          block_fill++;
          if (block_fill >= block_len) begin
            r.block_end = 1'b1;
            block_fill  = 0;
          end
        end else begin
          white_fill++;
        end
      end else begin
        pool_acc[pool_fill] = first_bit;
        if (pool_fill == '1) begin
          r.pool_valid = 1'b1;
          r.pool_byte  = pool_acc;
          r.pool_index = ring_pos[POOL_IDX_W-1:0];
          pool_acc     = '0;
          pool_fill    = '0;
          ring_pos++;
          if (ring_pos >= RING_BYTES) begin
            ring_pos     = 0;
            ring_wrapped = 1'b1;
          end
        end else begin
          pool_fill++;
        end
      end
    end
    r.pool_filled = ring_wrapped;
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] make_sample(input sample_kind_t kind);
    logic [SAMPLE_W-1:0] smp;
    smp = SAMPLE_W'($urandom);
    case (kind)
      KIND_SOLID: begin
        smp = {SAMPLE_W{smp[0]}};
      end
      KIND_UNEQUAL, KIND_EQUAL: begin
        for (int k = 0; k < PAIR_COUNT; k++)
          smp[2*k+1] = (kind == KIND_UNEQUAL) ? ~smp[2*k] : smp[2*k];
      end
      default: ;
    endcase
    return smp;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("mismatch at result word %0d: %s is %0h, expected %0h",
               results_checked, what, got, want);
  endtask

  // Compare the word on the result port with the oldest prediction.
  task automatic check_result;
    vnw_result_t want;
    if (whitened_words_due.size() == 0) begin
      report_mismatch("unexpected word, tdata", 32'(out_tdata), 32'd0);
      return;
    end
    want = whitened_words_due.pop_front();
    if (out_tuser[0] !== want.white_valid)
      report_mismatch("white_valid", 32'(out_tuser[0]), 32'(want.white_valid));
    if (out_tdata[7:0] !== want.white_byte)
      report_mismatch("white_byte", 32'(out_tdata[7:0]), 32'(want.white_byte));
    if (out_tlast !== want.block_end)
      report_mismatch("block_end", 32'(out_tlast), 32'(want.block_end));
    if (out_tuser[1] !== want.pool_valid)
      report_mismatch("pool_valid", 32'(out_tuser[1]), 32'(want.pool_valid));
    if (out_tdata[15:8] !== want.pool_byte)
      report_mismatch("pool_byte", 32'(out_tdata[15:8]), 32'(want.pool_byte));
    if (out_tdata[21:16] !== want.pool_index)
      report_mismatch("pool_index", 32'(out_tdata[21:16]), 32'(want.pool_index));
    if (out_tuser[2] !== want.pool_filled)
      report_mismatch("pool_filled", 32'(out_tuser[2]), 32'(want.pool_filled));
    if (out_tdata[TDATA_W-1:TDATA_USED_W] !== '0)
      report_mismatch("tdata padding", 32'(out_tdata[TDATA_W-1:TDATA_USED_W]), 32'd0);
    results_checked++;
    if (want.block_end)
      block_ends++;
    if (want.pool_filled)
      ring_seen_full = 1'b1;
  endtask

  // Result side: check each accepted word, then pick the ready for the next edge.
  // A hold-off request keeps ready low until its count runs out.
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        check_result();
      if (sink_hold_left > 0) begin
        sink_hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // Offer one sample word, possibly after a random gap with valid low, and predict its result
  // once the block takes it.
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    do @(posedge clk); while (!in_tready);
    whitened_words_due.push_back(whiten_sample(smp));
    samples_sent++;
  endtask

  task automatic send_burst(input int count, input sample_kind_t kind);
    sample_kind_t pick;
    for (int i = 0; i < count; i++) begin
      pick = kind;
      if (kind == KIND_MIXED) begin
        case ($urandom_range(0, 9)) inside
          [0:4]:   pick = KIND_ANY;
          [5:6]:   pick = KIND_UNEQUAL;
          [7:8]:   pick = KIND_EQUAL;
          default: pick = KIND_SOLID;
        endcase
      end
      send_sample(make_sample(pick));
    end
  endtask

  // Stop offering words and wait until every predicted word has come out.
  task automatic drain_results;
    in_tvalid <= 1'b0;
    while (whitened_words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // Register writes happen only with the block empty.
  task automatic write_block_len(input logic [BLOCK_W-1:0] len);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    block_len = len;
    cfg_writes++;
  endtask

  // Fixed samples: all zeros and ones, matching and differing pairs in both orders,
  // and the two ignored top bits on their own.
  task automatic test_pair_patterns;
    foreach (pair_patterns[i])
      send_sample(pair_patterns[i]);
  endtask

  // Zero behaves like one, one ends every block, and the largest length ends none in a short burst.
  task automatic test_block_length_edges;
    write_block_len('0);
    send_burst(12, KIND_UNEQUAL);
    write_block_len(16'd1);
    send_burst(12, KIND_UNEQUAL);
    write_block_len('1);
    send_burst(12, KIND_UNEQUAL);
    write_block_len(16'd2);
    send_burst(12, KIND_MIXED);
  endtask

  // Lowering the length below the bytes already counted ends the block on the next byte.
  task automatic test_shrink_block_len;
    write_block_len(16'd40);
    send_burst(24, KIND_UNEQUAL);
    write_block_len(16'd4);
    send_burst(16, KIND_UNEQUAL);
  endtask

  task automatic test_random_phases;
    logic [BLOCK_W-1:0] len;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       len = BLOCK_W'($urandom_range(1, 4));
        1:       len = BLOCK_W'($urandom_range(1, 12));
        2:       len = 16'd255;
        3:       len = BLOCK_W'($urandom_range(5, 40));
        4:       len = BLOCK_W'($urandom);
        default: len = BLOCK_W'($urandom_range(1, 3));
      endcase
      write_block_len(len);
      send_burst(240, KIND_MIXED);
    end
  endtask

  task automatic test_no_idle_stretch;
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    send_burst(200, KIND_MIXED);
    drain_results();
    src_idle_pct  = DEFAULT_IDLE;
    sink_idle_pct = DEFAULT_IDLE;
  endtask

  // The result side stalls long enough for the block to fill and push back on input.
  task automatic test_sink_holdoff;
    drain_results();
    src_idle_pct   = 0;
    sink_hold_left = 200;
    send_burst(80, KIND_MIXED);
    drain_results();
    src_idle_pct   = DEFAULT_IDLE;
  endtask

  // The sender stops until everything in flight has been delivered, then resumes.
  task automatic test_source_pause;
    send_burst(60, KIND_MIXED);
    drain_results();
    send_burst(60, KIND_MIXED);
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_pair_patterns();
    test_block_length_edges();
    test_shrink_block_len();
    test_random_phases();
    test_no_idle_stretch();
    test_sink_holdoff();
    test_source_pause();
    drain_results();
    $display("covered %0d sample words, %0d result words, %0d block ends, %0d length writes",
             samples_sent, results_checked, block_ends, cfg_writes);
    $display("discard ring wrapped during run: %0d, mismatches: %0d",
             ring_seen_full, mismatches);
    if (mismatches == 0 && whitened_words_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
